// ===== design/fcp_pkg.sv =====
// Shared types, constants and the CRC step for the framed command parser.
package fcp_pkg;

    // Parser phase codes.
    localparam logic [1:0] PHASE_SYNC1 = 2'd0;
    localparam logic [1:0] PHASE_SYNC2 = 2'd1;
    localparam logic [1:0] PHASE_BODY  = 2'd2;

    // Link status codes.
    localparam logic [1:0] LINK_OK      = 2'd0;
    localparam logic [1:0] LINK_CRC_ERR = 2'd1;
    localparam logic [1:0] LINK_LEN_ERR = 2'd2;
    localparam logic [1:0] LINK_SEQ_ERR = 2'd3;

    // Frame layout.
    localparam int          BodyBytes  = 14;
    localparam logic [3:0]  LenPos     = 4'd1;
    localparam logic [3:0]  CrcEndPos  = 4'd11;
    localparam logic [3:0]  LastPos    = 4'd13;
    localparam logic [7:0]  PayloadLen = 8'd9;

    // Command byte bits.
    localparam int CmdAimBit   = 0;
    localparam int CmdShootBit = 1;
    localparam int CmdStopBit  = 2;

    // Reset values.
    localparam logic [7:0]  SyncFirstRst  = 8'hAA;
    localparam logic [7:0]  SyncSecondRst = 8'h55;
    localparam logic [15:0] CrcInit       = 16'hFFFF;
    localparam logic [15:0] CrcPoly       = 16'h1021;
    localparam logic [7:0]  CmdRst        = 8'h01;

    // Configuration register indexes (paddr word select).
    localparam logic REG_SYNC_FIRST  = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    typedef logic [7:0] byte_t;

    // One byte of CRC16-CCITT, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input byte_t b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/framed_command_parser_core.sv =====
// Framed command parser: sync hunt, body capture, CRC16 check and command latch.
//
//  Channel   Direction  Handshake               Payload
//  s_        in         s_valid / s_ready       s_rx_byte, one received byte per request
//  m_        out        m_valid / m_ready       link status, latched frame data and flags
//  APB       in/out     psel/penable/pready     sync byte registers at 0x0 and 0x4
//
// Each request is registered, then parsed; one byte per cycle is sustained, save for the wait below.
// A result appears in the cycle after the request that causes it is processed.
// The result register is the latched state itself; while it waits, bytes that
// do not finish a frame keep flowing, and a byte that would finish one waits.
// Reset (aresetn low, synchronous) clears the parser to hunting the first sync byte.
module framed_command_parser_core (
    input  logic               aclk,
    input  logic               aresetn,
    // Byte input
    input  logic               s_valid,
    output logic               s_ready,
    input  fcp_pkg::byte_t     s_rx_byte,
    // Result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_link_status,
    output fcp_pkg::byte_t     m_peer_status,
    output fcp_pkg::byte_t     m_frame_seq,
    output logic               m_data_valid,
    output logic [31:0]        m_target_yaw_bits,
    output logic [31:0]        m_target_pitch_bits,
    output fcp_pkg::byte_t     m_command_byte,
    output logic               m_shoot_flag,
    output logic               m_send_flag,
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fcp_pkg::*;

    // Configuration registers.
    byte_t sync_first_reg, sync_second_reg;

    // Input stage.
    logic  in_valid_reg;
    byte_t in_byte_reg;

    // Parser state.
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    byte_t       body_reg [BodyBytes];
    logic [15:0] crc_reg, crc_next;
    logic        seen_reg, seen_next;

    // Latched result state, shown directly on the m_ port.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    byte_t       partner_reg, partner_next;
    byte_t       seq_reg, seq_next;
    logic        dvalid_reg, dvalid_next;
    logic [31:0] yaw_reg, yaw_next;
    logic [31:0] pitch_reg, pitch_next;
    byte_t       cmd_reg, cmd_next;
    logic        shoot_reg, shoot_next;
    logic        send_reg, send_next;

    logic        produce;
    logic        body_wr;
    logic        advance;
    logic [15:0] rx_crc;

    // Configuration port: writes in the access phase, reads return the register.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SyncFirstRst;
            sync_second_reg <= SyncSecondRst;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_SYNC_FIRST) begin
                sync_first_reg <= pwdata[7:0];
            end else begin
                sync_second_reg <= pwdata[7:0];
            end
        end
    end
    assign prdata = (paddr[2] == REG_SYNC_SECOND) ? {24'd0, sync_second_reg}
                                                  : {24'd0, sync_first_reg};

    // Received CRC is little-endian in the last two body bytes.
    assign rx_crc = {in_byte_reg, body_reg[12]};

    // Parse step for the registered byte.
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        seen_next    = seen_reg;
        status_next  = status_reg;
        partner_next = partner_reg;
        seq_next     = seq_reg;
        dvalid_next  = dvalid_reg;
        yaw_next     = yaw_reg;
        pitch_next   = pitch_reg;
        cmd_next     = cmd_reg;
        shoot_next   = shoot_reg;
        send_next    = send_reg;
        produce      = 1'b0;
        body_wr      = 1'b0;
        case (phase_reg)
            PHASE_SYNC1: begin
                if (in_byte_reg == sync_first_reg) begin
                    phase_next = PHASE_SYNC2;
                end
            end
            PHASE_SYNC2: begin
                if (in_byte_reg == sync_second_reg) begin
                    count_next = 4'd0;
                    crc_next   = CrcInit;
                    phase_next = PHASE_BODY;
                end else begin
                    phase_next = PHASE_SYNC1;
                end
            end
            PHASE_BODY: begin
                body_wr    = 1'b1;
                count_next = count_reg + 4'd1;
                if (count_reg <= CrcEndPos) begin
                    crc_next = crc_feed(crc_reg, in_byte_reg);
                end
                if (count_reg == LenPos && in_byte_reg != PayloadLen) begin
                    // Bad length is reported as soon as it arrives.
                    status_next = LINK_LEN_ERR;
                    dvalid_next = 1'b0;
                    phase_next  = PHASE_SYNC1;
                    count_next  = 4'd0;
                    produce     = 1'b1;
                end else if (count_reg == LastPos) begin
                    // Frame complete: check CRC, then sequence, then latch.
                    partner_next = body_reg[0];
                    phase_next   = PHASE_SYNC1;
                    count_next   = 4'd0;
                    produce      = 1'b1;
                    if (rx_crc != crc_reg) begin
                        status_next = LINK_CRC_ERR;
                        dvalid_next = 1'b0;
                    end else begin
                        if (seen_reg && body_reg[2] != seq_reg + 8'd1) begin
                            status_next = LINK_SEQ_ERR;
                        end else begin
                            status_next = LINK_OK;
                        end
                        dvalid_next = 1'b1;
                        seen_next   = 1'b1;
                        seq_next    = body_reg[2];
                        yaw_next    = {body_reg[6], body_reg[5], body_reg[4], body_reg[3]};
                        pitch_next  = {body_reg[10], body_reg[9], body_reg[8], body_reg[7]};
                        cmd_next    = body_reg[11];
                        if (body_reg[11][CmdStopBit]) begin
                            shoot_next = 1'b0;
                            send_next  = 1'b0;
                        end
                        if (body_reg[11][CmdAimBit]) begin
                            send_next = 1'b1;
                        end
                        if (body_reg[11][CmdShootBit]) begin
                            shoot_next = 1'b1;
                        end
                    end
                end
            end
            default: begin
                phase_next = PHASE_SYNC1;
                count_next = 4'd0;
            end
        endcase
    end

    // A byte moves on unless it makes a result while the last one still waits.
    assign advance = in_valid_reg && (!produce || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (advance && produce) begin
            out_valid_next = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Body byte store, written at the running byte position.
    always_ff @(posedge aclk) begin
        if (advance && body_wr) begin
            body_reg[count_reg] <= in_byte_reg;
        end
    end

    // Parser and result state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_SYNC1;
            count_reg     <= 4'd0;
            crc_reg       <= CrcInit;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= LINK_OK;
            partner_reg   <= 8'd0;
            seq_reg       <= 8'd0;
            dvalid_reg    <= 1'b0;
            yaw_reg       <= 32'd0;
            pitch_reg     <= 32'd0;
            cmd_reg       <= CmdRst;
            shoot_reg     <= 1'b0;
            send_reg      <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                crc_reg     <= crc_next;
                seen_reg    <= seen_next;
                status_reg  <= status_next;
                partner_reg <= partner_next;
                seq_reg     <= seq_next;
                dvalid_reg  <= dvalid_next;
                yaw_reg     <= yaw_next;
                pitch_reg   <= pitch_next;
                cmd_reg     <= cmd_next;
                shoot_reg   <= shoot_next;
                send_reg    <= send_next;
            end
        end
    end

    // Result port.
    assign m_valid             = out_valid_reg;
    assign m_link_status       = status_reg;
    assign m_peer_status       = partner_reg;
    assign m_frame_seq         = seq_reg;
    assign m_data_valid        = dvalid_reg;
    assign m_target_yaw_bits   = yaw_reg;
    assign m_target_pitch_bits = pitch_reg;
    assign m_command_byte      = cmd_reg;
    assign m_shoot_flag        = shoot_reg;
    assign m_send_flag         = send_reg;

endmodule

// ===== design/fcp_checker.sv =====
// Port-level checks for the framed command parser, bound to the top level.
module fcp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_link_status,
    input logic               m_data_valid,
    input logic [31:0]        m_target_yaw_bits,
    input fcp_pkg::byte_t     m_command_byte,
    input logic               m_send_flag
);
    import fcp_pkg::*;

    // A waiting result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result request dropped before it was taken");

    // Latched data counts as valid only for an ok or sequence-error status.
    a_valid_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_valid |-> m_link_status == LINK_OK || m_link_status == LINK_SEQ_ERR)
        else $error("valid data reported with a CRC or length error");

    // A rejected frame always carries an error status.
    a_reject_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data_valid |->
            m_link_status == LINK_CRC_ERR || m_link_status == LINK_LEN_ERR)
        else $error("rejected frame reported without an error status");

    // Stop without aim leaves the send request cleared.
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data_valid && m_command_byte[CmdStopBit] && !m_command_byte[CmdAimBit]
            |-> !m_send_flag)
        else $error("send request survived a stop command");

    // A waiting result keeps its payload.
    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_target_yaw_bits))
        else $error("result payload changed while stalled");

endmodule

bind framed_command_parser_core fcp_checker u_fcp_checker (.*);

// ===== verif/fcp_checker.sv =====
// Byte-stream predictor and result comparator for the framed command parser.
module fcp_scoreboard (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  fcp_pkg::byte_t s_rx_byte,
    input  logic           m_valid,
    input  logic           m_ready,
    input  logic [1:0]     m_link_status,
    input  fcp_pkg::byte_t m_peer_status,
    input  fcp_pkg::byte_t m_frame_seq,
    input  logic           m_data_valid,
    input  logic [31:0]    m_target_yaw_bits,
    input  logic [31:0]    m_target_pitch_bits,
    input  fcp_pkg::byte_t m_command_byte,
    input  logic           m_shoot_flag,
    input  logic           m_send_flag,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             err_cnt,
    output int             open_cnt
);
    import fcp_pkg::*;

    // One link report, in the order of the result ports.
    typedef struct packed {
        logic [1:0]  link;
        byte_t       peer;
        byte_t       seq;
        logic        dv;
        logic [31:0] yaw;
        logic [31:0] pitch;
        byte_t       cmd;
        logic        shoot;
        logic        send;
    } link_report_t;

    link_report_t reports_due[$];
    int           fail_total = 0;
    int           due_total  = 0;

    // Shadow of the parser and its latched command state.
    logic [1:0]   phase;
    int           fill;
    byte_t        body [BodyBytes];
    logic [15:0]  crc;
    logic [1:0]   link_q;
    byte_t        peer_q;
    byte_t        last_seq_q;
    logic         seq_seen_q;
    logic [31:0]  yaw_q;
    logic [31:0]  pitch_q;
    byte_t        cmd_q;
    logic         shoot_q;
    logic         send_q;
    byte_t        sync_first_q;
    byte_t        sync_second_q;

    assign err_cnt  = fail_total;
    assign open_cnt = due_total;

    // CRC16-CCITT, one input bit at a time with the feedback taken from the top bit.
    function automatic logic [15:0] crc_shift(input logic [15:0] c, input byte_t b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CrcPoly;
            end
        end
        return r;
    endfunction

    // The report shows the held state plus this frame's data-valid bit.
    function automatic link_report_t held_state(input logic dv);
        return '{link_q, peer_q, last_seq_q, dv, yaw_q, pitch_q, cmd_q, shoot_q, send_q};
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a report is due.
    function automatic bit parse_byte(input byte_t b, output link_report_t rep);
        bit    frame_ok;
        byte_t seq_next;
        case (phase)
            PHASE_SYNC1: begin
                if (b == sync_first_q) begin
                    phase = PHASE_SYNC2;
                end
            end
            PHASE_SYNC2: begin
                // A mismatch drops back to the hunt without a second look at this byte.
                if (b == sync_second_q) begin
                    fill  = 0;
                    crc   = CrcInit;
                    phase = PHASE_BODY;
                end else begin
                    phase = PHASE_SYNC1;
                end
            end
            PHASE_BODY: begin
                body[fill] = b;
                if (fill <= CrcEndPos) begin
                    crc = crc_shift(crc, b);
                end
                fill++;
                // The length byte is judged as soon as it lands.
                if (fill == 2 && body[LenPos] != PayloadLen) begin
                    link_q = LINK_LEN_ERR;
                    phase  = PHASE_SYNC1;
                    fill   = 0;
                    rep    = held_state(1'b0);
                    return 1'b1;
                end
                if (fill == BodyBytes) begin
                    peer_q   = body[0];
                    frame_ok = ({body[LastPos], body[LastPos - 4'd1]} == crc);
                    if (!frame_ok) begin
                        link_q = LINK_CRC_ERR;
                    end else begin
                        // Any sequence number is fine for the first good frame.
                        seq_next = last_seq_q + 8'd1;
                        link_q   = (seq_seen_q && body[2] != seq_next) ? LINK_SEQ_ERR : LINK_OK;
                        seq_seen_q = 1'b1;
                        last_seq_q = body[2];
                        yaw_q      = {body[6], body[5], body[4], body[3]};
                        pitch_q    = {body[10], body[9], body[8], body[7]};
                        cmd_q      = body[11];
                        // Stop clears first, then aim and shoot may set again.
                        if (cmd_q[CmdStopBit]) begin
                            shoot_q = 1'b0;
                            send_q  = 1'b0;
                        end
                        if (cmd_q[CmdAimBit]) begin
                            send_q = 1'b1;
                        end
                        if (cmd_q[CmdShootBit]) begin
                            shoot_q = 1'b1;
                        end
                    end
                    phase = PHASE_SYNC1;
                    fill  = 0;
                    rep   = held_state(frame_ok);
                    return 1'b1;
                end
            end
            default: begin
                phase = PHASE_SYNC1;
                fill  = 0;
            end
        endcase
        return 1'b0;
    endfunction

    // Watch all three ports at each edge: results first, then requests, then writes.
    always @(posedge aclk) begin : watch
        link_report_t got;
        link_report_t want;
        if (!aresetn) begin
            phase         = PHASE_SYNC1;
            fill          = 0;
            crc           = CrcInit;
            link_q        = LINK_OK;
            peer_q        = '0;
            last_seq_q    = '0;
            seq_seen_q    = 1'b0;
            yaw_q         = '0;
            pitch_q       = '0;
            cmd_q         = CmdRst;
            shoot_q       = 1'b0;
            send_q        = 1'b0;
            sync_first_q  = SyncFirstRst;
            sync_second_q = SyncSecondRst;
            reports_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_link_status, m_peer_status, m_frame_seq, m_data_valid,
                        m_target_yaw_bits, m_target_pitch_bits, m_command_byte,
                        m_shoot_flag, m_send_flag};
                if (reports_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("unexpected result: link %0d seq %h valid %0d cmd %h",
                                 got.link, got.seq, got.dv, got.cmd);
                    end
                end else begin
                    want = reports_due.pop_front();
                    if (got !== want) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("result mismatch (expected/actual): link %0d/%0d peer %h/%h",
                                     want.link, got.link, want.peer, got.peer);
                            $display("  seq %h/%h valid %0d/%0d yaw %h/%h pitch %h/%h",
                                     want.seq, got.seq, want.dv, got.dv,
                                     want.yaw, got.yaw, want.pitch, got.pitch);
                            $display("  cmd %h/%h shoot %0d/%0d send %0d/%0d",
                                     want.cmd, got.cmd, want.shoot, got.shoot,
                                     want.send, got.send);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (parse_byte(s_rx_byte, want)) begin
                    reports_due.push_back(want);
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SYNC_FIRST) begin
                    sync_first_q = pwdata[7:0];
                end else begin
                    sync_second_q = pwdata[7:0];
                end
            end
        end
        due_total <= reports_due.size();
    end

endmodule

// ===== verif/tb_framed_command_parser_core.sv =====
// Stimulus and verdict for the framed command parser: directed frames, then random traffic.
module tb_framed_command_parser_core;
    import fcp_pkg::*;

    localparam int PhaseItems   = 220;
    localparam int SettleCycles = 6;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    byte_t          s_rx_byte = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    logic [1:0]     m_link_status;
    byte_t          m_peer_status;
    byte_t          m_frame_seq;
    logic           m_data_valid;
    logic [31:0]    m_target_yaw_bits;
    logic [31:0]    m_target_pitch_bits;
    byte_t          m_command_byte;
    logic           m_shoot_flag;
    logic           m_send_flag;
    logic           psel      = 1'b0;
    logic           penable   = 1'b0;
    logic           pwrite    = 1'b0;
    logic [2:0]     paddr     = '0;
    logic [31:0]    pwdata    = '0;
    logic [31:0]    prdata;
    logic           pready;

    int    fail_count;
    int    reports_open;
    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    int    frame_bytes   = 0;
    byte_t first_sync    = SyncFirstRst;
    byte_t second_sync   = SyncSecondRst;
    byte_t gen_seq       = 8'hFF;

    framed_command_parser_core dut (.*);

    fcp_scoreboard frame_chk (.*, .err_cnt(fail_count), .open_cnt(reports_open));

    // Clock.
    always #1 aclk = ~aclk;

    // Receiver side: stall at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Give up after a generous fixed time.
    initial begin
        #800000;
        $display("tb_framed_command_parser_core failed");
        $finish;
    end

    // CRC16-CCITT over one byte, bit by bit, for building frames.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input byte_t b);
        logic [15:0] r;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            r = (r[15] ^ b[i]) ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // Byte values biased toward the extremes and the current sync values.
    function automatic byte_t pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return first_sync;
            3:       return second_sync;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // One request on the byte channel, after a random idle stretch.
    task automatic send_byte(input byte_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        frame_bytes += 1;
    endtask

    // Sync pair plus a full body; the CRC is correct unless corrupted on purpose.
    task automatic send_frame(input byte_t st, input byte_t len, input byte_t seq,
                              input logic [71:0] payload, input bit corrupt);
        byte_t       body [BodyBytes];
        logic [15:0] crc;
        crc     = CrcInit;
        body[0] = st;
        body[1] = len;
        body[2] = seq;
        for (int i = 0; i < 9; i++) begin
            body[3 + i] = payload[8 * i +: 8];
        end
        for (int i = 0; i <= CrcEndPos; i++) begin
            crc = crc_step(crc, body[i]);
        end
        {body[13], body[12]} = crc;
        if (corrupt) begin
            body[12 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
        end
        send_byte(first_sync);
        send_byte(second_sync);
        foreach (body[i]) begin
            send_byte(body[i]);
        end
    endtask

    // Write both sync registers back to back; the bus stays selected between them.
    task automatic write_syncs(input byte_t first_val, input byte_t second_val);
        for (int i = 0; i < 2; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {(i == 0) ? REG_SYNC_FIRST : REG_SYNC_SECOND, 2'b00};
            pwdata  <= {24'($urandom), (i == 0) ? first_val : second_val};
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
        end
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        first_sync  = first_val;
        second_sync = second_val;
    endtask

    // Wait until every expected report has come back, then let the pipeline settle.
    task automatic drain(input int settle);
        @(posedge aclk);
        while (reports_open != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Mostly well-formed frames with random content, the rest broken framing and noise.
    task automatic random_traffic(input int budget);
        int          start;
        int          r;
        int          n;
        byte_t       cmd;
        byte_t       seq;
        byte_t       len;
        start = frame_bytes;
        while (frame_bytes - start < budget) begin
            r   = $urandom_range(99);
            cmd = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom);
            if (r < 70) begin
                // Good frames, then CRC errors, sequence jumps and bad lengths.
                seq = (r >= 58 && r < 64) ? gen_seq + 8'($urandom_range(254, 1)) : gen_seq;
                len = (r >= 64) ? (PayloadLen ^ 8'($urandom_range(255, 1))) : PayloadLen;
                send_frame(pick_byte(), len, seq, {cmd, pick_word(), pick_word()},
                           r >= 50 && r < 58);
                if (r < 50 || (r >= 58 && r < 64)) begin
                    gen_seq = seq + 8'd1;
                end
            end else if (r < 78) begin
                n = $urandom_range(4, 1);
                repeat (n) send_byte(pick_byte());
            end else if (r < 85) begin
                // First sync followed by the wrong second byte.
                send_byte(first_sync);
                send_byte(second_sync ^ 8'($urandom_range(255, 1)));
            end else if (r < 91) begin
                // A repeated first sync ahead of the second sync byte.
                send_byte(first_sync);
                send_byte(first_sync);
                send_byte(second_sync);
            end else begin
                // Frame cut short; whatever follows is taken as body.
                n = $urandom_range(13, 1);
                send_byte(first_sync);
                send_byte(second_sync);
                repeat (n) send_byte(pick_byte());
            end
        end
    endtask

    // Reset, then phases that differ in idling, in stalling and in the sync values.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            case (p)
                0: begin
                    // Extremes as noise, a repeated first sync, then a length error.
                    send_byte(8'h00);
                    send_byte(8'hFF);
                    send_byte(first_sync);
                    send_byte(first_sync);
                    send_byte(second_sync);
                    send_byte(first_sync);
                    send_byte(second_sync);
                    send_byte(8'hFF);
                    send_byte(8'h00);
                    // First good frame: stop, aim and shoot, sync values in the payload.
                    send_frame(8'h00, PayloadLen, gen_seq,
                               {8'h07, 32'h00FF_55AA, 32'h00FF_55AA}, 1'b0);
                    gen_seq = gen_seq + 8'd1;
                end
                1:       write_syncs(8'h00, 8'hFF);
                2:       write_syncs(8'hFF, 8'h00);
                3:       write_syncs(8'h7E, 8'h7E);
                4:       write_syncs(SyncFirstRst, SyncSecondRst);
                default: write_syncs(8'($urandom), 8'($urandom));
            endcase
            random_traffic(PhaseItems);
            s_valid <= 1'b0;
            drain((p == 7) ? 50 : SettleCycles);
        end
        if (fail_count == 0) begin
            $display("tb_framed_command_parser_core passed");
        end else begin
            $display("tb_framed_command_parser_core failed");
        end
        $finish;
    end

endmodule
